// ===== sv/slt_pkg.sv =====
// Package with shared types, constants and keyword lookup for the lexical scanner.
package slt_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int KW_MAX_LEN_DEF  = 6;
  localparam int OUT_W           = 20;
  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
  localparam logic [19:0] LINE_MAX  = 20'hFFFFF;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_EQ     = 6'd13;
  localparam logic [5:0] K_GT     = 6'd15;
  localparam logic [5:0] K_LT     = 6'd17;
  localparam logic [5:0] K_STRING = 6'd19;
  localparam logic [5:0] K_INT    = 6'd20;
  localparam logic [5:0] K_FLOAT  = 6'd21;
  localparam logic [5:0] K_IDENT  = 6'd22;
  localparam logic [5:0] K_KW0    = 6'd23;
  localparam logic [5:0] K_END    = 6'd43;
  localparam logic [5:0] K_ERRCH  = 6'd44;
  localparam logic [5:0] K_ERRSTR = 6'd45;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_SLASH, M_COMMENT, M_STRING, M_INT, M_INTDOT, M_FLOAT, M_IDENT
  } mode_t;

  // What the front end hands to the back end for each token.
  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start_res;
    logic [19:0] length;
    logic [19:0] line;
    logic [30:0] int_value;
    logic        overflow;
    logic        last_result;
  } tok_t;

  // Keyword buffer holds up to six characters, newest in the low byte.
  function automatic logic [5:0] kw_kind(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (w[15:0] == "if") k = K_KW0 + 6'd6;
        if (w[15:0] == "or") k = K_KW0 + 6'd8;
      end
      3'd3: begin
        if (w[23:0] == "and") k = K_KW0;
        if (w[23:0] == "fun") k = K_KW0 + 6'd4;
        if (w[23:0] == "for") k = K_KW0 + 6'd5;
        if (w[23:0] == "NOV") k = K_KW0 + 6'd7;
        if (w[23:0] == "int") k = K_KW0 + 6'd15;
      end
      3'd4: begin
        if (w[31:0] == "else") k = K_KW0 + 6'd2;
        if (w[31:0] == "self") k = K_KW0 + 6'd12;
        if (w[31:0] == "this") k = K_KW0 + 6'd13;
        if (w[31:0] == "true") k = K_KW0 + 6'd14;
        if (w[31:0] == "bool") k = K_KW0 + 6'd17;
      end
      3'd5: begin
        if (w[39:0] == "class") k = K_KW0 + 6'd1;
        if (w[39:0] == "false") k = K_KW0 + 6'd3;
        if (w[39:0] == "print") k = K_KW0 + 6'd9;
        if (w[39:0] == "super") k = K_KW0 + 6'd11;
        if (w[39:0] == "float") k = K_KW0 + 6'd16;
        if (w[39:0] == "while") k = K_KW0 + 6'd19;
      end
      3'd6: begin
        if (w == "return") k = K_KW0 + 6'd10;
        if (w == "string") k = K_KW0 + 6'd18;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/slt_front.sv =====
// Front end: one byte per cycle when step is high; up to four tokens per byte.
module slt_front #(
  parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF,
  parameter int KW_MAX_LEN  = slt_pkg::KW_MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       ch,
  input  logic             eos,
  output logic [2:0]       n_tok,
  output slt_pkg::tok_t    tok [4]
);

  localparam int LW = $clog2(KW_MAX_LEN + 2);

  slt_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [OFFSET_BITS-1:0] beg_r, beg_nxt, pos_r, pos_nxt;
  logic [19:0] line_r, line_nxt;
  logic [47:0] wbuf_r, wbuf_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;

  function automatic logic [19:0] o20(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[19:0];
  endfunction

  function automatic logic [5:0] held_kind(input logic [7:0] h);
    case (h)
      "!": return slt_pkg::K_BANG;
      "=": return slt_pkg::K_EQ;
      ">": return slt_pkg::K_GT;
      default: return slt_pkg::K_LT;
    endcase
  endfunction

  always_comb begin
    logic consumed, isd, isa;
    logic [34:0] prod;
    logic [OFFSET_BITS-1:0] p, e;
    slt_pkg::tok_t t;
    logic [2:0] n;
    slt_pkg::tok_t q [4];
    mode_nxt = mode_r; held_nxt = held_r; beg_nxt = beg_r; pos_nxt = pos_r;
    line_nxt = line_r; wbuf_nxt = wbuf_r; wlen_nxt = wlen_r; acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    consumed = 1'b1;
    p = pos_r;
    e = pos_r;
    n = 3'd0;
    t = '0;
    for (int i = 0; i < 4; i++) q[i] = '0;
    isd = (ch >= "0") && (ch <= "9");
    isa = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    prod = 35'(acc_r) * 35'd10 + 35'(ch - 8'h30);

    case (mode_r)
      slt_pkg::M_OP:
        if (ch == "=") begin
          t = '0; t.kind = held_kind(held_r) + 6'd1; t.start_res = o20(beg_r);
          t.length = 20'd2; t.line = line_nxt; q[n[1:0]] = t; n = n + 3'd1;
          mode_nxt = slt_pkg::M_IDLE;
        end else consumed = 1'b0;
      slt_pkg::M_SLASH:
        if (ch == "/") mode_nxt = slt_pkg::M_COMMENT;
        else consumed = 1'b0;
      slt_pkg::M_COMMENT:
        if (ch == 8'h0A) begin mode_nxt = slt_pkg::M_IDLE; consumed = 1'b0; end
      slt_pkg::M_STRING:
        if (ch == "\"") begin
          t = '0; t.kind = slt_pkg::K_STRING; t.start_res = o20(beg_r);
          t.length = o20(p - beg_r - OFFSET_BITS'(1)); t.line = line_nxt;
          q[n[1:0]] = t; n = n + 3'd1;
          mode_nxt = slt_pkg::M_IDLE;
        end else if (ch == 8'h0A && line_nxt != slt_pkg::LINE_MAX)
          line_nxt = line_nxt + 20'd1;
      slt_pkg::M_INT:
        if (isd) begin
          if (prod > 35'(slt_pkg::INT_MAX31)) begin
            acc_nxt = slt_pkg::INT_MAX31; ovf_nxt = 1'b1;
          end else acc_nxt = prod[30:0];
        end else if (ch == ".") mode_nxt = slt_pkg::M_INTDOT;
        else consumed = 1'b0;
      slt_pkg::M_INTDOT:
        if (isd) mode_nxt = slt_pkg::M_FLOAT;
        else consumed = 1'b0;
      slt_pkg::M_FLOAT:
        if (!isd) consumed = 1'b0;
      slt_pkg::M_IDENT:
        if (isa || isd) begin
          if (32'(wlen_r) < KW_MAX_LEN) wbuf_nxt = {wbuf_r[39:0], ch};
          if (32'(wlen_r) <= KW_MAX_LEN) wlen_nxt = wlen_r + LW'(1);
        end else consumed = 1'b0;
      default: consumed = 1'b0;
    endcase

    // Two closing passes: on the unconsumed byte, and at end of source.
    for (int pass = 0; pass < 2; pass++) begin
      if ((pass == 0 && !consumed) || (pass == 1 && eos)) begin
        e = (pass == 0) ? p : p + OFFSET_BITS'(1);
        t = '0; t.line = line_nxt;
        case (mode_nxt)
          slt_pkg::M_OP: begin
            t.kind = held_kind(held_nxt); t.start_res = o20(beg_nxt); t.length = 20'd1;
            q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_SLASH: begin
            t.kind = slt_pkg::K_SLASH; t.start_res = o20(beg_nxt); t.length = 20'd1;
            q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_STRING: begin
            t.kind = slt_pkg::K_ERRSTR; t.start_res = o20(beg_nxt);
            t.length = o20(e - beg_nxt); q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_INT: begin
            t.kind = slt_pkg::K_INT; t.start_res = o20(beg_nxt);
            t.length = o20(e - beg_nxt); t.int_value = acc_nxt; t.overflow = ovf_nxt;
            q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_INTDOT: begin
            t.kind = slt_pkg::K_INT; t.start_res = o20(beg_nxt);
            t.length = o20(e - OFFSET_BITS'(1) - beg_nxt); t.int_value = acc_nxt;
            t.overflow = ovf_nxt; q[n[1:0]] = t; n = n + 3'd1;
            t = '0; t.line = line_nxt; t.kind = slt_pkg::K_DOT;
            t.start_res = o20(e - OFFSET_BITS'(1)); t.length = 20'd1;
            q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_FLOAT: begin
            t.kind = slt_pkg::K_FLOAT; t.start_res = o20(beg_nxt);
            t.length = o20(e - beg_nxt); q[n[1:0]] = t; n = n + 3'd1;
          end
          slt_pkg::M_IDENT: begin
            t.kind = (32'(wlen_nxt) > KW_MAX_LEN) ? slt_pkg::K_IDENT
                   : slt_pkg::kw_kind(wbuf_nxt, 3'(wlen_nxt));
            t.start_res = o20(beg_nxt); t.length = o20(e - beg_nxt);
            q[n[1:0]] = t; n = n + 3'd1;
          end
          default: ;
        endcase
        mode_nxt = slt_pkg::M_IDLE;
        if (pass == 0) begin
          t = '0; t.line = line_nxt; t.start_res = o20(p); t.length = 20'd1;
          case (ch)
            "(": t.kind = slt_pkg::K_LPAREN;
            ")": t.kind = slt_pkg::K_RPAREN;
            "{": t.kind = slt_pkg::K_LBRACE;
            "}": t.kind = slt_pkg::K_RBRACE;
            ",": t.kind = slt_pkg::K_COMMA;
            ".": t.kind = slt_pkg::K_DOT;
            "-": t.kind = slt_pkg::K_MINUS;
            "+": t.kind = slt_pkg::K_PLUS;
            ";": t.kind = slt_pkg::K_SEMI;
            "*": t.kind = slt_pkg::K_STAR;
            default: t.kind = slt_pkg::K_ERRCH;
          endcase
          if (ch == "!" || ch == "=" || ch == "<" || ch == ">") begin
            mode_nxt = slt_pkg::M_OP; held_nxt = ch; beg_nxt = p;
          end else if (ch == "/") begin
            mode_nxt = slt_pkg::M_SLASH; beg_nxt = p;
          end else if (ch == " " || ch == 8'h0D || ch == 8'h09) begin
          end else if (ch == 8'h0A) begin
            if (line_nxt != slt_pkg::LINE_MAX) line_nxt = line_nxt + 20'd1;
          end else if (ch == "\"") begin
            mode_nxt = slt_pkg::M_STRING; beg_nxt = p;
          end else if (isd) begin
            mode_nxt = slt_pkg::M_INT; beg_nxt = p;
            acc_nxt = 31'(ch - 8'h30); ovf_nxt = 1'b0;
          end else if (isa) begin
            mode_nxt = slt_pkg::M_IDENT; beg_nxt = p;
            wbuf_nxt = {40'd0, ch}; wlen_nxt = LW'(1);
          end else begin
            q[n[1:0]] = t; n = n + 3'd1;
          end
        end else begin
          t = '0; t.line = line_nxt; t.kind = slt_pkg::K_END; t.start_res = o20(e);
          q[n[1:0]] = t; n = n + 3'd1;
        end
      end
    end
    pos_nxt = p + OFFSET_BITS'(1);
    if (n != 3'd0) q[2'(n - 3'd1)].last_result = 1'b1;
    if (eos) begin
      mode_nxt = slt_pkg::M_IDLE; held_nxt = '0; beg_nxt = '0; pos_nxt = '0;
      line_nxt = 20'd1; wbuf_nxt = '0; wlen_nxt = '0; acc_nxt = '0; ovf_nxt = 1'b0;
    end
    n_tok = n;
    tok = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slt_pkg::M_IDLE; held_r <= '0; beg_r <= '0; pos_r <= '0;
      line_r <= 20'd1; wbuf_r <= '0; wlen_r <= '0; acc_r <= '0; ovf_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt; held_r <= held_nxt; beg_r <= beg_nxt; pos_r <= pos_nxt;
      line_r <= line_nxt; wbuf_r <= wbuf_nxt; wlen_r <= wlen_nxt;
      acc_r <= acc_nxt; ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== sv/slt_queue.sv =====
// Token queue, scanner to output: takes up to four per cycle, gives one if out_ready.
module slt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    wr_n,
  input  slt_pkg::tok_t wr_tok [4],
  output logic          has_room,
  output logic          out_valid,
  input  logic          out_ready,
  output slt_pkg::tok_t out_tok
);

  localparam int DEPTH = 8;

  slt_pkg::tok_t mem_r [DEPTH];
  logic [2:0] rd_r, wr_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 4'd0;
  assign out_tok   = mem_r[rd_r];
  // Room for a worst-case byte of four tokens, without counting on this cycle's pop.
  assign has_room  = cnt_r <= 4'd4;
  assign cnt_nxt   = cnt_r + 4'(wr_n) - 4'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      if (3'(i) < wr_n) mem_r[wr_r + 3'(i)] <= wr_tok[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + wr_n;
      rd_r  <= rd_r + 3'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/source_lexer_tokenizer.sv =====
// Top level of the streaming lexical scanner.
// A token that a byte closes is written into the token queue as the byte is accepted.
// Throughput: one byte per cycle while the eight-entry token queue has room for
// four more; output drains one token per cycle while out_tready is high.
// Reset: synchronous active-low rst_n empties the queue and returns the scanner
// to idle at offset 0, line 1.
module source_lexer_tokenizer #(
  parameter int OFFSET_BITS     = slt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = slt_pkg::KW_MAX_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // ch
  input  logic         in_tlast,   // end_of_source
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // kind, start_res, length, line, int_value, overflow
  output logic         out_tlast   // last_result
);

  logic step;
  logic [2:0] n_tok;
  slt_pkg::tok_t tok [4];
  slt_pkg::tok_t q_tok;
  logic [2:0] wr_n;

  assign step = in_tvalid && in_tready;
  assign wr_n = step ? n_tok : 3'd0;

  slt_front #(.OFFSET_BITS(OFFSET_BITS), .KW_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .ch(in_tdata), .eos(in_tlast),
    .n_tok(n_tok), .tok(tok)
  );

  slt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_n(wr_n), .wr_tok(tok), .has_room(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_tok(q_tok)
  );

  assign out_tdata = {6'd0, q_tok.overflow, q_tok.int_value, q_tok.line,
                      q_tok.length, q_tok.start_res, q_tok.kind};
  assign out_tlast = q_tok.last_result;

endmodule

// ===== sv/slt_checker.sv =====
// Port-level checker for the lexical scanner, bound to the top level.
module slt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == slt_pkg::K_END |-> out_tlast)
    else $error("end token not marked last");

  // The end token of a finished source is always queued on the next cycle.
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result item after the final byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= slt_pkg::K_ERRSTR)
    else $error("kind out of range");

  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:46] != 20'd0)
    else $error("line number zero");

endmodule

bind source_lexer_tokenizer slt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);

// ===== sim/tb_source_lexer_tokenizer.sv =====
// Self-checking testbench for the streaming lexical scanner, with its own token predictor.
module tb_source_lexer_tokenizer;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // ch
  logic         in_tlast;   // end_of_source
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // kind, start_res, length, line, int_value, overflow
  logic         out_tlast;  // last_result

  source_lexer_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  localparam int RANDOM_BYTES = 240;
  localparam int IDLE_LIMIT   = 5000;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Scanner state as the predictor sees it.
  slt_pkg::mode_t sc_mode;
  logic [7:0]  sc_held;
  logic [19:0] sc_begin;
  logic [19:0] sc_pos;
  logic [19:0] sc_line;
  logic [47:0] sc_word;
  logic [2:0]  sc_wlen;
  logic [30:0] sc_acc;
  logic        sc_ovf;

  slt_pkg::tok_t step_tokens[$];
  slt_pkg::tok_t tokens_due[$];

  string keywords[20] = '{"and", "class", "else", "false", "fun", "for", "if", "NOV", "or",
                          "print", "return", "super", "self", "this", "true",
                          "int", "float", "bool", "string", "while"};

  int errors = 0;
  int bytes_fed = 0;
  int tokens_seen = 0;
  int sources_closed = 0;

  function automatic void scanner_clear();
    sc_mode = slt_pkg::M_IDLE;
    sc_held = 8'd0;
    sc_begin = 20'd0;
    sc_pos = 20'd0;
    sc_line = 20'd1;
    sc_word = 48'd0;
    sc_wlen = 3'd0;
    sc_acc = 31'd0;
    sc_ovf = 1'b0;
  endfunction

  function automatic void add_token(logic [5:0] k, logic [19:0] st, logic [19:0] len,
                                    logic [30:0] ival, logic ov);
    slt_pkg::tok_t t;
    t.kind = k;
    t.start_res = st;
    t.length = len;
    t.line = sc_line;
    t.int_value = ival;
    t.overflow = ov;
    t.last_result = 1'b0;
    if (step_tokens.size() < 4) step_tokens = {step_tokens, t};
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] word_kind();
    string       s;
    logic [47:0] packed_word;
    for (int i = 0; i < 20; i++) begin
      s = keywords[i];
      if (s.len() == sc_wlen) begin
        packed_word = 48'd0;
        for (int j = 0; j < s.len(); j++) packed_word = (packed_word << 8) | s[j];
        if (packed_word == sc_word) return slt_pkg::K_KW0 + 6'(i);
      end
    end
    return slt_pkg::K_IDENT;
  endfunction

  function automatic logic [5:0] held_kind();
    case (sc_held)
      "!": return slt_pkg::K_BANG;
      "=": return slt_pkg::K_EQ;
      ">": return slt_pkg::K_GT;
      default: return slt_pkg::K_LT;
    endcase
  endfunction

  function automatic void bump_line();
    if (sc_line != slt_pkg::LINE_MAX) sc_line = sc_line + 20'd1;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [63:0] v;
    v = 64'(sc_acc) * 64'd10 + 64'(c - "0");
    if (v > 64'(slt_pkg::INT_MAX31)) begin
      v = 64'(slt_pkg::INT_MAX31);
      sc_ovf = 1'b1;
    end
    sc_acc = v[30:0];
  endfunction

  // Emit whatever token is still open; e is the offset just past its last byte.
  function automatic void close_open_token(logic [19:0] e);
    case (sc_mode)
      slt_pkg::M_OP: add_token(held_kind(), sc_begin, 20'd1, 31'd0, 1'b0);
      slt_pkg::M_SLASH: add_token(slt_pkg::K_SLASH, sc_begin, 20'd1, 31'd0, 1'b0);
      slt_pkg::M_STRING: add_token(slt_pkg::K_ERRSTR, sc_begin, e - sc_begin, 31'd0, 1'b0);
      slt_pkg::M_INT: add_token(slt_pkg::K_INT, sc_begin, e - sc_begin, sc_acc, sc_ovf);
      slt_pkg::M_INTDOT: begin
        add_token(slt_pkg::K_INT, sc_begin, e - 20'd1 - sc_begin, sc_acc, sc_ovf);
        add_token(slt_pkg::K_DOT, e - 20'd1, 20'd1, 31'd0, 1'b0);
      end
      slt_pkg::M_FLOAT: add_token(slt_pkg::K_FLOAT, sc_begin, e - sc_begin, 31'd0, 1'b0);
      slt_pkg::M_IDENT: add_token(word_kind(), sc_begin, e - sc_begin, 31'd0, 1'b0);
      default: ;
    endcase
    sc_mode = slt_pkg::M_IDLE;
  endfunction

  function automatic void start_lexeme(logic [7:0] c, logic [19:0] p);
    case (c)
      "(": add_token(slt_pkg::K_LPAREN, p, 20'd1, 31'd0, 1'b0);
      ")": add_token(slt_pkg::K_RPAREN, p, 20'd1, 31'd0, 1'b0);
      "{": add_token(slt_pkg::K_LBRACE, p, 20'd1, 31'd0, 1'b0);
      "}": add_token(slt_pkg::K_RBRACE, p, 20'd1, 31'd0, 1'b0);
      ",": add_token(slt_pkg::K_COMMA, p, 20'd1, 31'd0, 1'b0);
      ".": add_token(slt_pkg::K_DOT, p, 20'd1, 31'd0, 1'b0);
      "-": add_token(slt_pkg::K_MINUS, p, 20'd1, 31'd0, 1'b0);
      "+": add_token(slt_pkg::K_PLUS, p, 20'd1, 31'd0, 1'b0);
      ";": add_token(slt_pkg::K_SEMI, p, 20'd1, 31'd0, 1'b0);
      "*": add_token(slt_pkg::K_STAR, p, 20'd1, 31'd0, 1'b0);
      "!", "=", "<", ">": begin
        sc_mode = slt_pkg::M_OP;
        sc_held = c;
        sc_begin = p;
      end
      "/": begin
        sc_mode = slt_pkg::M_SLASH;
        sc_begin = p;
      end
      " ", "\r", "\t": ;
      "\n": bump_line();
      "\"": begin
        sc_mode = slt_pkg::M_STRING;
        sc_begin = p;
      end
      default: begin
        if (is_digit(c)) begin
          sc_mode = slt_pkg::M_INT;
          sc_begin = p;
          sc_acc = 31'd0;
          sc_ovf = 1'b0;
          add_digit(c);
        end else if (is_letter(c)) begin
          sc_mode = slt_pkg::M_IDENT;
          sc_begin = p;
          sc_word = 48'(c);
          sc_wlen = 3'd1;
        end else begin
          add_token(slt_pkg::K_ERRCH, p, 20'd1, 31'd0, 1'b0);
        end
      end
    endcase
  endfunction

  // Work out the tokens that one accepted byte causes and queue them.
  function automatic void predict_tokens(logic [7:0] c, logic eos);
    logic [19:0] p;
    bit          taken;
    p = sc_pos;
    taken = 1'b1;
    step_tokens.delete();
    case (sc_mode)
      slt_pkg::M_OP: begin
        if (c == "=") begin
          add_token(held_kind() + 6'd1, sc_begin, 20'd2, 31'd0, 1'b0);
          sc_mode = slt_pkg::M_IDLE;
        end else taken = 1'b0;
      end
      slt_pkg::M_SLASH: begin
        if (c == "/") sc_mode = slt_pkg::M_COMMENT;
        else taken = 1'b0;
      end
      slt_pkg::M_COMMENT: begin
        if (c == "\n") begin
          sc_mode = slt_pkg::M_IDLE;
          taken = 1'b0;
        end
      end
      slt_pkg::M_STRING: begin
        if (c == "\"") begin
          add_token(slt_pkg::K_STRING, sc_begin, p - sc_begin - 20'd1, 31'd0, 1'b0);
          sc_mode = slt_pkg::M_IDLE;
        end else if (c == "\n") bump_line();
      end
      slt_pkg::M_INT: begin
        if (is_digit(c)) add_digit(c);
        else if (c == ".") sc_mode = slt_pkg::M_INTDOT;
        else taken = 1'b0;
      end
      slt_pkg::M_INTDOT: begin
        if (is_digit(c)) sc_mode = slt_pkg::M_FLOAT;
        else taken = 1'b0;
      end
      slt_pkg::M_FLOAT: begin
        if (!is_digit(c)) taken = 1'b0;
      end
      slt_pkg::M_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          if (sc_wlen < 3'd6) sc_word = (sc_word << 8) | 48'(c);
          if (sc_wlen <= 3'd6) sc_wlen = sc_wlen + 3'd1;
        end else taken = 1'b0;
      end
      default: taken = 1'b0;
    endcase
    if (!taken) begin
      close_open_token(p);
      start_lexeme(c, p);
    end
    sc_pos = p + 20'd1;
    if (eos) begin
      close_open_token(sc_pos);
      add_token(slt_pkg::K_END, sc_pos, 20'd0, 31'd0, 1'b0);
      scanner_clear();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    foreach (step_tokens[i]) tokens_due = {tokens_due, step_tokens[i]};
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    predict_tokens(c, eos);
    bytes_fed++;
    if (eos) sources_closed++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Source text for the random part, one item per entry.
  logic [7:0] text_ch[$];
  logic       text_eos[$];

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_ch = {text_ch, s[i]};
      text_eos = {text_eos, 1'b0};
    end
  endfunction

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic void put_digits(int n);
    for (int i = 0; i < n; i++) put_text(string'(8'($urandom_range("0", "9"))));
  endfunction

  function automatic void make_lexeme();
    string ops[12] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*", "/", "!"};
    string twins[4] = '{"!", "=", "<", ">"};
    string seps[5] = '{" ", " ", "\n", "\t", "\r"};
    int n;
    case ($urandom_range(0, 12))
      0, 1: put_text(keywords[$urandom_range(0, 19)]);
      2, 3: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++)
          put_text(string'(($urandom_range(0, 3) == 0 && i > 0) ?
                           8'($urandom_range("0", "9")) : any_letter()));
      end
      4: put_digits($urandom_range(1, 12));
      5: begin
        put_digits($urandom_range(1, 3));
        put_text(".");
        put_digits($urandom_range(1, 3));
      end
      6: begin
        put_digits($urandom_range(1, 3));
        put_text(".");
      end
      7: begin
        put_text("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          put_text($urandom_range(0, 4) == 0 ? "\n" : string'(any_letter()));
        if ($urandom_range(0, 7) != 0) put_text("\"");
      end
      8: begin
        put_text("//");
        put_text(string'(any_letter()));
        if ($urandom_range(0, 3) != 0) put_text("\n");
      end
      9: put_text(ops[$urandom_range(0, 11)]);
      10: begin
        put_text(twins[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1)) put_text("=");
      end
      11: begin
        text_ch = {text_ch, 8'($urandom_range(0, 255))};
        text_eos = {text_eos, 1'b0};
      end
      default: begin
        text_ch = {text_ch, 8'($urandom_range(0, 255))};
        text_eos = {text_eos, 1'b1};
      end
    endcase
    if ($urandom_range(0, 4) != 0) put_text(seps[$urandom_range(0, 4)]);
  endfunction

  // Directed table: byte, end mark, and a typed expectation where one is obvious.
  logic [7:0]  row_ch[$];
  logic        row_eos[$];
  bit          row_typed[$];
  logic [5:0]  row_kind[$];
  logic [19:0] row_start[$];

  task automatic add_row(logic [7:0] c, logic eos, bit typed, logic [5:0] k, logic [19:0] st);
    row_ch = {row_ch, c};
    row_eos = {row_eos, eos};
    row_typed = {row_typed, typed};
    row_kind = {row_kind, k};
    row_start = {row_start, st};
  endtask

  initial begin
    string rest;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tlast = 1'b0;
    scanner_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row("(", 1'b0, 1'b1, slt_pkg::K_LPAREN, 20'd0);
    add_row(8'hFF, 1'b0, 1'b1, slt_pkg::K_ERRCH, 20'd1);
    add_row(8'h00, 1'b0, 1'b1, slt_pkg::K_ERRCH, 20'd2);
    rest = "!=<9999999999 1.x2.5\"s\n\"//c\n";
    for (int i = 0; i < rest.len(); i++)
      add_row(rest[i], 1'b0, 1'b0, slt_pkg::K_END, 20'd0);
    add_row("\"", 1'b1, 1'b0, slt_pkg::K_END, 20'd0);

    foreach (row_ch[i]) begin
      send_byte(row_ch[i], row_eos[i]);
      if (row_typed[i]) begin
        tokens_due[tokens_due.size() - 1].kind = row_kind[i];
        tokens_due[tokens_due.size() - 1].start_res = row_start[i];
        tokens_due[tokens_due.size() - 1].length = 20'd1;
      end
    end

    for (int n = 0; n < RANDOM_BYTES; n++) begin
      if (text_ch.size() == 0) make_lexeme();
      if (n == RANDOM_BYTES / 2) begin
        // Let the token queue drain completely before going on.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (tokens_due.size() != 0);
      end
      send_byte(text_ch.pop_front(), text_eos.pop_front());
    end
    send_byte(" ", 1'b1);
    in_tvalid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Fed %0d bytes over %0d sources; %0d tokens compared field by field.",
             bytes_fed, sources_closed, tokens_seen);
    if (errors == 0)
      $display("tb_source_lexer_tokenizer OK");
    else
      $display("tb_source_lexer_tokenizer NOT OK");
    $finish;
  end

  // Receiver stalls on its own pattern, with stretches of no stalling.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) out_tready <= 1'b0;
    else if (cycle_count[7:6] == 2'd0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0) && (cycle_count[2:0] != 3'd5);
  end

  always @(posedge clk) begin
    slt_pkg::tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        $error("token with no expectation: kind %0d", out_tdata[5:0]);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        if (out_tdata[5:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tdata[5:0]);
          errors++;
        end
        if (out_tdata[25:6] !== want.start_res) begin
          $error("start_res: expected %0d, got %0d", want.start_res, out_tdata[25:6]);
          errors++;
        end
        if (out_tdata[45:26] !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_tdata[45:26]);
          errors++;
        end
        if (out_tdata[65:46] !== want.line) begin
          $error("line: expected %0d, got %0d", want.line, out_tdata[65:46]);
          errors++;
        end
        if (out_tdata[96:66] !== want.int_value) begin
          $error("int_value: expected %0d, got %0d", want.int_value, out_tdata[96:66]);
          errors++;
        end
        if (out_tdata[97] !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_tdata[97]);
          errors++;
        end
        if (out_tlast !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, out_tlast);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_source_lexer_tokenizer NOT OK");
      $finish;
    end
  end

endmodule
